FILE: rtl/mcr_pkg.sv
// Shared widths, codes and beat types of the midpoint circle rasterizer.
package mcr_pkg;

   localparam int COORD_BITS = 10;
   localparam int PT_BITS    = COORD_BITS + 2;
   localparam int INC_BITS   = COORD_BITS + 2;
   localparam int DEC_BITS   = COORD_BITS + 3;

   localparam int QUEUE_DEPTH_DEFAULT = 2;

   localparam logic MODE_START = 1'b0;
   localparam logic MODE_STEP  = 1'b1;

   localparam int OCT_BITS = 3;
   localparam logic [OCT_BITS-1:0] OCT_FIRST = 3'd0;
   localparam logic [OCT_BITS-1:0] OCT_LAST  = 3'd7;

   typedef struct packed {
      logic                  mode;
      logic [COORD_BITS-1:0] radius;
      logic [COORD_BITS-1:0] center_x;
      logic [COORD_BITS-1:0] center_y;
   } req_item_type;

   typedef struct packed {
      logic signed [PT_BITS-1:0] point_x;
      logic signed [PT_BITS-1:0] point_y;
      logic                      last_point;
      logic                      done_res;
   } rsp_item_type;

   typedef struct packed {
      logic                  done;
      logic [COORD_BITS-1:0] pos_x;
      logic [COORD_BITS-1:0] pos_y;
      logic [COORD_BITS-1:0] origin_x;
      logic [COORD_BITS-1:0] origin_y;
   } job_type;

   typedef struct packed {
      logic push;
      logic pop;
      logic full;
      logic empty;
   } queue_ctl_type;

endpackage

FILE: rtl/mcr_front.sv
// Front end: takes request beats, keeps the octant walk state, queues step jobs.
module mcr_front import mcr_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_accept,
   input  req_item_type req_item,
   output logic         job_push,
   output job_type      job_data
);

   logic [COORD_BITS-1:0] pos_x_ff, pos_x_in;
   logic [COORD_BITS-1:0] pos_y_ff, pos_y_in;
   logic [DEC_BITS-1:0]   decision_ff, decision_in;
   logic [INC_BITS-1:0]   x_inc_ff, x_inc_in;
   logic [INC_BITS-1:0]   y_dec_ff, y_dec_in;
   logic [COORD_BITS-1:0] origin_x_ff, origin_x_in;
   logic [COORD_BITS-1:0] origin_y_ff, origin_y_in;

   logic                  finished;
   logic                  dec_pos;
   logic [DEC_BITS-1:0]   dec_adj;

   assign finished = pos_x_ff > pos_y_ff;
   assign dec_pos  = !decision_ff[DEC_BITS-1] && (decision_ff != '0);
   assign dec_adj  = dec_pos ? decision_ff - {y_dec_ff[INC_BITS-1], y_dec_ff} : decision_ff;

   assign job_push          = req_accept && (req_item.mode == MODE_STEP);
   assign job_data.done     = finished;
   assign job_data.pos_x    = pos_x_ff;
   assign job_data.pos_y    = pos_y_ff;
   assign job_data.origin_x = origin_x_ff;
   assign job_data.origin_y = origin_y_ff;

   always_comb begin
      pos_x_in    = pos_x_ff;
      pos_y_in    = pos_y_ff;
      decision_in = decision_ff;
      x_inc_in    = x_inc_ff;
      y_dec_in    = y_dec_ff;
      origin_x_in = origin_x_ff;
      origin_y_in = origin_y_ff;
      if (req_accept) begin
         if (req_item.mode == MODE_START) begin
            origin_x_in = req_item.center_x;
            origin_y_in = req_item.center_y;
            x_inc_in    = INC_BITS'(3);
            if (req_item.radius == '0) begin
               // zero radius loads an already finished walk
               pos_x_in    = COORD_BITS'(1);
               pos_y_in    = '0;
               decision_in = '0;
               y_dec_in    = '0;
            end else begin
               pos_x_in    = '0;
               pos_y_in    = req_item.radius;
               decision_in = DEC_BITS'(1) - {3'b000, req_item.radius};
               y_dec_in    = {1'b0, req_item.radius, 1'b0} - INC_BITS'(2);
            end
         end else if (!finished) begin
            decision_in = dec_adj + {1'b0, x_inc_ff};
            x_inc_in    = x_inc_ff + INC_BITS'(2);
            pos_x_in    = pos_x_ff + COORD_BITS'(1);
            if (dec_pos) begin
               y_dec_in = y_dec_ff - INC_BITS'(2);
               pos_y_in = pos_y_ff - COORD_BITS'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff    <= '0;
         pos_y_ff    <= '0;
         decision_ff <= '0;
         x_inc_ff    <= INC_BITS'(3);
         y_dec_ff    <= '0;
         origin_x_ff <= '0;
         origin_y_ff <= '0;
      end else begin
         pos_x_ff    <= pos_x_in;
         pos_y_ff    <= pos_y_in;
         decision_ff <= decision_in;
         x_inc_ff    <= x_inc_in;
         y_dec_ff    <= y_dec_in;
         origin_x_ff <= origin_x_in;
         origin_y_ff <= origin_y_in;
      end
   end

endmodule

FILE: rtl/mcr_job_fifo.sv
// Short job queue between the front end and the point emitter.
module mcr_job_fifo import mcr_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  job_type       push_data,
   input  logic          pop,
   output job_type       head_data,
   output logic          full,
   output logic          empty
);

   localparam int PTR_BITS = $clog2(DEPTH);
   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam logic [PTR_BITS-1:0] PTR_LAST  = PTR_BITS'(DEPTH - 1);
   localparam logic [CNT_BITS-1:0] CNT_DEPTH = CNT_BITS'(DEPTH);

   job_type               slot_ff [DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic                  do_push;
   logic                  do_pop;

   assign full      = count_ff == CNT_DEPTH;
   assign empty     = count_ff == '0;
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign head_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_BITS'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_DEPTH)
      else $error("job queue count beyond depth");

endmodule

FILE: rtl/mcr_back.sv
// Back end: expands each queued job into its eight mirrored points or one done beat.
module mcr_back import mcr_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  job_type       job_head,
   input  queue_ctl_type job_ctl,
   output logic          job_pop,
   output rsp_item_type  rsp_item,
   output logic          rsp_valid
);

   logic [OCT_BITS-1:0]   oct_ff, oct_in;
   logic                  out_valid_ff;
   rsp_item_type          out_data_ff;
   logic                  load;
   logic                  have_job;
   logic                  job_end;
   rsp_item_type          beat;
   logic [COORD_BITS-1:0] coord_a;
   logic [COORD_BITS-1:0] coord_b;
   logic [PT_BITS-1:0]    off_a;
   logic [PT_BITS-1:0]    off_b;

   assign load     = !out_valid_ff || job_ctl.pop;
   assign have_job = !job_ctl.empty;
   assign job_end  = job_head.done || (oct_ff == OCT_LAST);
   assign job_pop  = load && have_job && job_end;

   // bit 2 swaps x and y, bit 0 negates the column, bit 1 negates the row
   assign coord_a = oct_ff[2] ? job_head.pos_y : job_head.pos_x;
   assign coord_b = oct_ff[2] ? job_head.pos_x : job_head.pos_y;
   assign off_a   = oct_ff[0] ? -{2'b00, coord_a} : {2'b00, coord_a};
   assign off_b   = oct_ff[1] ? -{2'b00, coord_b} : {2'b00, coord_b};

   always_comb begin
      if (job_head.done) begin
         beat.point_x    = '0;
         beat.point_y    = '0;
         beat.last_point = 1'b0;
         beat.done_res   = 1'b1;
      end else begin
         beat.point_x    = off_a + {2'b00, job_head.origin_x};
         beat.point_y    = off_b + {2'b00, job_head.origin_y};
         beat.last_point = oct_ff == OCT_LAST;
         beat.done_res   = 1'b0;
      end
   end

   always_comb begin
      oct_in = oct_ff;
      if (load && have_job) begin
         oct_in = job_end ? OCT_FIRST : oct_ff + OCT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oct_ff       <= OCT_FIRST;
         out_valid_ff <= 1'b0;
      end else begin
         oct_ff <= oct_in;
         if (load) begin
            out_valid_ff <= have_job;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_data_ff <= beat;
      end
   end

   assign rsp_item  = out_data_ff;
   assign rsp_valid = out_valid_ff;

   a_job_held: assert property (@(posedge clock) disable iff (reset)
      oct_ff != OCT_FIRST |-> !job_ctl.empty)
      else $error("octant walk without a job at the queue head");

   a_last_pops: assert property (@(posedge clock) disable iff (reset)
      load && have_job && !job_head.done && oct_ff == OCT_LAST |-> job_pop)
      else $error("eighth point did not retire its job");

   a_done_clean: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_data_ff.done_res |->
         out_data_ff.point_x == '0 && out_data_ff.point_y == '0 && !out_data_ff.last_point)
      else $error("done beat carries point data");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      job_ctl.push |-> !job_ctl.full)
      else $error("job pushed into a full queue");

endmodule

FILE: rtl/midpoint_circle_rasterizer_top.sv
// Top level of the midpoint circle rasterizer: front end, job queue and point emitter.
// A start beat (mode 0) loads radius and center and yields no result.
// Each step beat (mode 1) yields eight mirrored points, one per cycle while pop
// keeps up, the eighth flagged last_point; once the octant walk is past x > y a step
// yields a single beat with done_res set. The single result register holds each
// beat until pop takes it. The first beat of a step passes through the job queue and
// then the result register. A queue of QUEUE_DEPTH jobs lets requests be taken
// while earlier points are still being emitted or held by pop.
module midpoint_circle_rasterizer_top import mcr_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   output logic         full,
   input  req_item_type req_item,
   output logic         empty,
   input  logic         pop,
   output rsp_item_type rsp_item
);

   logic          req_accept;
   logic          job_push;
   job_type       job_in;
   job_type       job_head;
   logic          job_pop;
   logic          job_full;
   logic          job_empty;
   logic          rsp_valid;
   queue_ctl_type job_ctl;

   assign full       = job_full;
   assign req_accept = push && !job_full;
   assign empty      = !rsp_valid;

   assign job_ctl.push  = job_push;
   assign job_ctl.pop   = pop && rsp_valid;
   assign job_ctl.full  = job_full;
   assign job_ctl.empty = job_empty;

   mcr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .req_item   (req_item),
      .job_push   (job_push),
      .job_data   (job_in)
   );

   mcr_job_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_job_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (job_ctl.push),
      .push_data (job_in),
      .pop       (job_pop),
      .head_data (job_head),
      .full      (job_full),
      .empty     (job_empty)
   );

   mcr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_head  (job_head),
      .job_ctl   (job_ctl),
      .job_pop   (job_pop),
      .rsp_item  (rsp_item),
      .rsp_valid (rsp_valid)
   );

endmodule
